@@ rtl/core/fadet_pkg.sv @@
// ----------------------------------------------------------------------------
// fadet_pkg
// Shared types and constants of the frame-average motion detector: register
// indexes, field widths, arithmetic constants, control state and the request
// and result bundles of the percent divider.
// ----------------------------------------------------------------------------
`default_nettype none

package fadet_pkg;

  // field widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 8;
  localparam int ACC_W   = 24;
  localparam int PCT_W   = 16;
  localparam int HIST_W  = 32;
  localparam int IDX_W   = 3;
  localparam int FCNT_W  = 4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_AVG_FRAMES  = 3'd0;
  localparam logic [IDX_W-1:0] REG_AREA_LEFT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_AREA_TOP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_AREA_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_AREA_HEIGHT = 3'd4;
  localparam logic [IDX_W-1:0] REG_MIN_MOTION  = 3'd5;
  localparam logic [IDX_W-1:0] REG_MAX_MOTION  = 3'd6;

  // percent scale and divide-by-three reciprocal (exact for sums up to 765)
  localparam int PERCENT_SCALE = 100;
  localparam int DIV3_MUL      = 683;
  localparam int DIV3_SHIFT    = 11;

  // frame counter saturates here
  localparam logic [FCNT_W-1:0] FCNT_MAX = 4'hF;

  // percent divider: |sum-min|*100 < 2^31, |max-min| < 2^24
  localparam int DIV_NUM_W = 31;
  localparam int DIV_DEN_W = 24;
  localparam int DIV_STEPS = DIV_NUM_W;
  localparam int DIV_CNT_W = 5;

  localparam logic signed [PCT_W-1:0] PCT_SAT_HI = 16'sh7FFF;
  localparam logic signed [PCT_W-1:0] PCT_SAT_LO = 16'sh8000;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DIV,
    ST_REPORT
  } fadet_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic                 neg;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [PCT_W-1:0] percent;
  } div_res_t;

endpackage

`default_nettype wire

@@ rtl/core/frame_average_motion_detector.sv @@
// ----------------------------------------------------------------------------
// frame_average_motion_detector
// Per-pixel background subtraction against the average of the last one to
// four frames, with a motion sum over a watched rectangle reported at the end
// of each frame after warm-up. While the output is taken, ordinary pixels
// flow at one per clock through a three-stage path (history read,
// read-modify-write, output register); history lives in a MAX_WIDTH*MAX_HEIGHT
// x 32-bit single-port-write memory with registered read, and a back-to-back
// pixel at the same position takes its history from a forwarding register. An
// end-of-frame pixel that produces a report with distinct trip and full-scale
// levels holds the pipe while the percent divider forms 31 quotient bits.
// After reset the block clears the history memory one entry per clock and
// accepts no pixels until done; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_average_motion_detector #(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int WARMUP_FRAMES = 10
) (
  input  logic        clk,
  input  logic        rst,
  // pixel stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pixel[7:0], col[15:8], row[23:16]
  input  logic        s_tlast,   // end_of_frame
  // result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // diff_value[7:0], motion_sum[31:8],
                                 // motion_percent[47:32], triggered[48], zero pad
  output logic        m_tuser,   // area_valid
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import fadet_pkg::*;

  localparam int HIST_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);
  localparam int COL_MW     = (MAX_WIDTH >= 256) ? COORD_W : $clog2(MAX_WIDTH);
  localparam int ROW_MW     = (MAX_HEIGHT >= 256) ? COORD_W : $clog2(MAX_HEIGHT);

  // configuration registers
  logic [2:0]        average_frames;
  logic [7:0]        area_left;
  logic [8:0]        area_top;
  logic [8:0]        area_width;
  logic [8:0]        area_height;
  logic [ACC_W-1:0]  trip_level;
  logic [ACC_W-1:0]  full_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_frames <= 3'd4;
      area_left      <= '0;
      area_top       <= '0;
      area_width     <= '0;
      area_height    <= '0;
      trip_level     <= '0;
      full_level     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AVG_FRAMES:  average_frames <= cfg_data[2:0];
        REG_AREA_LEFT:   area_left      <= cfg_data[7:0];
        REG_AREA_TOP:    area_top       <= cfg_data[8:0];
        REG_AREA_WIDTH:  area_width     <= cfg_data[8:0];
        REG_AREA_HEIGHT: area_height    <= cfg_data[8:0];
        REG_MIN_MOTION:  trip_level     <= cfg_data;
        REG_MAX_MOTION:  full_level     <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  fadet_state_t state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic clearing, running, report_ok;

  // pipeline registers
  logic              v1, v2, ov;
  logic [ADDR_W-1:0] addr1;
  logic [PIX_W-1:0]  pixel1;
  logic              fwd1, area1, eof1;
  logic [PIX_W-1:0]  diff2;
  logic              area2, eof2;
  logic [HIST_W-1:0] last_wr;
  logic [HIST_W-1:0] mem_q;
  logic [ACC_W-1:0]  acc;
  logic [FCNT_W-1:0] frame_count;

  // output register
  logic [PIX_W-1:0]        o_diff;
  logic                    o_valid;
  logic [ACC_W-1:0]        o_sum;
  logic signed [PCT_W-1:0] o_pct;
  logic                    o_trig;

  logic accept, s1_go, s2_go, out_free;
  logic need_div, report_en;

  div_req_t div_req;
  div_res_t div_res;

  // input fields
  logic [PIX_W-1:0]   in_pixel;
  logic [COORD_W-1:0] in_col, in_row;
  assign in_pixel = s_tdata[7:0];
  assign in_col   = s_tdata[15:8];
  assign in_row   = s_tdata[23:16];

  // coordinate wrap tables, resolved at elaboration
  logic [COL_MW-1:0] col_mod [256];
  logic [ROW_MW-1:0] row_mod [256];
  for (genvar i = 0; i < 256; i++) begin : g_wrap
    assign col_mod[i] = COL_MW'(i % MAX_WIDTH);
    assign row_mod[i] = ROW_MW'(i % MAX_HEIGHT);
  end

  logic [ADDR_W-1:0] rd_addr;
  assign rd_addr = ADDR_W'(ADDR_W'(row_mod[in_row]) * ADDR_W'(MAX_WIDTH))
                 + ADDR_W'(col_mod[in_col]);

  // rectangle test: columns unsigned, rows signed
  logic               in_area;
  logic signed [10:0] row_s, top_s, bot_s;
  always_comb begin
    row_s   = $signed({3'b000, in_row});
    top_s   = $signed({{2{area_top[8]}}, area_top});
    bot_s   = top_s + $signed({2'b00, area_height});
    in_area = (in_col >= area_left)
           && ({2'b00, in_col} < ({2'b00, area_left} + {1'b0, area_width}))
           && (row_s >= top_s) && (row_s < bot_s);
  end

  // handshakes through the pipe
  assign out_free = !ov || m_tready;
  assign s2_go    = v2 && out_free && (!need_div || report_ok);
  assign s1_go    = v1 && (!v2 || s2_go);
  assign s_tready = running && (!v1 || s1_go);
  assign accept   = s_tvalid && s_tready;

  // ---- stage 1: history, average, difference ----
  logic [HIST_W-1:0] hist;
  logic [PIX_W-1:0]  h1, h2, h3, h4, avg, diff1;
  logic [8:0]        sum2;
  logic [9:0]        sum3, sum4;
  logic [19:0]       div3_prod;

  always_comb begin
    hist      = fwd1 ? last_wr : mem_q;
    h1        = hist[7:0];
    h2        = hist[15:8];
    h3        = hist[23:16];
    h4        = hist[31:24];
    sum2      = {1'b0, h1} + {1'b0, h2};
    sum3      = {1'b0, sum2} + {2'b00, h3};
    sum4      = sum3 + {2'b00, h4};
    div3_prod = 20'(sum3) * 20'(DIV3_MUL);
    priority if (average_frames < 3'd2) avg = h1;
    else if (average_frames == 3'd2)    avg = sum2[8:1];
    else if (average_frames == 3'd3)    avg = div3_prod[DIV3_SHIFT +: PIX_W];
    else                                avg = sum4[9:2];
    diff1 = (pixel1 >= avg) ? (pixel1 - avg) : (avg - pixel1);
  end

  // history memory: clear sweep or shift-in write, read on accept
  logic [HIST_W-1:0] hist_mem [HIST_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [HIST_W-1:0] mem_wdata;

  always_comb begin
    mem_we    = clearing || s1_go;
    mem_waddr = clearing ? clr_addr : addr1;
    mem_wdata = clearing ? '0 : {hist[23:0], pixel1};
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
    if (accept) mem_q <= hist_mem[rd_addr];
  end

  // ---- stage 2: accumulate, percent request ----
  logic [ACC_W:0]          acc_sum;
  logic [ACC_W-1:0]        acc_total;
  logic signed [ACC_W+1:0] num_s;
  logic [ACC_W-1:0]        num_mag;
  logic signed [ACC_W:0]   span_s;
  logic [ACC_W-1:0]        span_mag;
  logic                    span_zero;

  always_comb begin
    acc_sum   = {1'b0, acc} + (area2 ? (ACC_W+1)'(diff2) : '0);
    acc_total = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    num_s     = $signed({2'b00, acc_total}) - $signed({2'b00, trip_level});
    num_mag   = num_s[ACC_W+1] ? ACC_W'(-num_s) : num_s[ACC_W-1:0];
    span_s    = $signed({1'b0, full_level}) - $signed({1'b0, trip_level});
    span_mag  = span_s[ACC_W] ? ACC_W'(-span_s) : span_s[ACC_W-1:0];
    span_zero = (full_level == trip_level);
    report_en = frame_count > FCNT_W'(WARMUP_FRAMES);
    need_div  = eof2 && report_en && !span_zero;
  end

  // divider request, started once per reporting end-of-frame beat whose trip and full-scale levels differ
  always_comb begin
    div_req.start = (state == ST_RUN) && v2 && need_div;
    div_req.num   = DIV_NUM_W'(num_mag) * DIV_NUM_W'(PERCENT_SCALE);
    div_req.den   = span_mag;
    div_req.neg   = num_s[ACC_W+1] ^ span_s[ACC_W];
  end

  fadet_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // ---- control FSM ----
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == ADDR_W'(HIST_DEPTH - 1)) state_next = ST_RUN;
      ST_RUN:    if (v2 && need_div) state_next = ST_DIV;
      ST_DIV:    if (div_res.done) state_next = ST_REPORT;
      ST_REPORT: if (s2_go) state_next = ST_RUN;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = (state == ST_CLEAR);
    running   = (state != ST_CLEAR);
    report_ok = (state == ST_REPORT);
  end

  // clear sweep address
  always_ff @(posedge clk) begin
    if (rst)           clr_addr <= '0;
    else if (clearing) clr_addr <= clr_addr + 1'b1;
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (accept)     v1 <= 1'b1;
      else if (s1_go) v1 <= 1'b0;
      if (s1_go)      v2 <= 1'b1;
      else if (s2_go) v2 <= 1'b0;
      if (s2_go)         ov <= 1'b1;
      else if (m_tready) ov <= 1'b0;
    end
  end

  // stage payloads; forward when the item ahead writes the same entry
  always_ff @(posedge clk) begin
    if (accept) begin
      addr1  <= rd_addr;
      pixel1 <= in_pixel;
      area1  <= in_area;
      eof1   <= s_tlast;
      fwd1   <= s1_go && (addr1 == rd_addr);
    end
    if (s1_go) begin
      last_wr <= {hist[23:0], pixel1};
      diff2   <= diff1;
      area2   <= area1;
      eof2    <= eof1;
    end
  end

  // frame accumulator and warm-up counter
  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      frame_count <= '0;
    end else if (s2_go) begin
      acc <= eof2 ? '0 : acc_total;
      if (eof2 && frame_count != FCNT_MAX) frame_count <= frame_count + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s2_go) begin
      o_diff <= diff2;
      if (eof2 && report_en) begin
        o_valid <= 1'b1;
        o_sum   <= acc_total;
        o_pct   <= span_zero ? '0 : div_res.percent;
        o_trig  <= acc_total > trip_level;
      end else begin
        o_valid <= 1'b0;
        o_sum   <= '0;
        o_pct   <= '0;
        o_trig  <= 1'b0;
      end
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {7'b0000000, o_trig, o_pct, o_sum, o_diff};
  assign m_tuser  = o_valid;

endmodule

`default_nettype wire

@@ rtl/core/fadet_div.sv @@
// ----------------------------------------------------------------------------
// fadet_div
// Radix-2 restoring divider for the motion percent. Divides magnitudes one
// quotient bit per cycle, then applies the sign and saturates to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fadet_div (
  input  logic                 clk,
  input  logic                 rst,
  input  fadet_pkg::div_req_t  req,
  output fadet_pkg::div_res_t  res
);
  import fadet_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] dvs;
  logic                 neg;

  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W+1:0] trial;
  logic                 fits;
  logic [DIV_DEN_W-1:0] rem_next;
  logic [DIV_NUM_W-1:0] quo_next;

  // one restoring step: bring down the next dividend bit, try subtract
  always_comb begin
    shifted  = {rem, quo[DIV_NUM_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs};
    fits     = !trial[DIV_DEN_W+1];
    rem_next = fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
    quo_next = {quo[DIV_NUM_W-2:0], fits};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      dvs <= req.den;
      neg <= req.neg;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  // sign and saturation; stable until the next start
  always_comb begin
    res.done = done;
    if (!neg) begin
      if (quo > DIV_NUM_W'(32767)) res.percent = PCT_SAT_HI;
      else                         res.percent = $signed(quo[PCT_W-1:0]);
    end else begin
      if (quo > DIV_NUM_W'(32768)) res.percent = PCT_SAT_LO;
      else                         res.percent = $signed(PCT_W'(~quo[PCT_W-1:0] + 1'b1));
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_frame_average_motion_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_average_motion_detector
// Self-checking bench for the frame-average motion detector. Pixel beats are
// queued by the stimulus process, driven on the slave stream by a clocked
// driver, and mirrored at acceptance into a cycle-free model of the per-pixel
// history, the rectangle sum and the end-of-frame report. Every accepted
// output beat is checked field by field against the oldest prediction. The
// run covers warm-up, the percent corner cases and randomized frame sweeps
// under several sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_frame_average_motion_detector;
  import fadet_pkg::*;

  localparam int WARMUP        = 10;
  localparam int DRAIN_CYCLES  = 48;
  localparam int MAX_ERR_LINES = 40;

  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] col;
    logic [7:0] row;
    logic       eof;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0]  diff;
    logic        area_valid;
    logic [23:0] sum;
    logic [15:0] percent;
    logic        triggered;
  } motion_result_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data  = '0;

  pixel_beat_t    pixel_q[$];
  motion_result_t motion_due_q[$];
  logic           in_beat = 1'b0;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             errors = 0;

  // mirrored detector state
  bit [31:0]   hist_mem [0:65535];
  int unsigned motion_acc  = 0;
  int          frames_seen = 0;
  int unsigned avg_sel  = 4;
  int unsigned left_col = 0;
  int          top_row  = 0;
  int unsigned rect_w   = 0;
  int unsigned rect_h   = 0;
  int unsigned min_mot  = 0;
  int unsigned max_mot  = 0;

  frame_average_motion_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (errors < MAX_ERR_LINES) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
    errors++;
  endtask

  // history average, abs difference, rectangle sum and frame report
  task automatic predict_motion(input pixel_beat_t px, output motion_result_t res);
    logic [31:0] h;
    int unsigned avg;
    int unsigned pix;
    int unsigned d;
    longint      span;
    longint      pct;
    h   = hist_mem[{px.row, px.col}];
    pix = 32'(px.pixel);
    if (avg_sel < 2) begin
      avg = 32'(h[7:0]);
    end else if (avg_sel == 2) begin
      avg = (32'(h[7:0]) + 32'(h[15:8])) >> 1;
    end else if (avg_sel == 3) begin
      avg = (32'(h[7:0]) + 32'(h[15:8]) + 32'(h[23:16])) / 3;
    end else begin
      avg = (32'(h[7:0]) + 32'(h[15:8]) + 32'(h[23:16]) + 32'(h[31:24])) >> 2;
    end
    d = (pix >= avg) ? pix - avg : avg - pix;
    hist_mem[{px.row, px.col}] = {h[23:0], px.pixel};

    if (int'(px.col) >= int'(left_col) && int'(px.col) < int'(left_col + rect_w) &&
        int'(px.row) >= top_row && int'(px.row) < top_row + int'(rect_h)) begin
      motion_acc = motion_acc + d;
      if (motion_acc > 32'hFF_FFFF) motion_acc = 32'hFF_FFFF;
    end

    res = '0;
    res.diff = d[7:0];
    if (px.eof) begin
      if (frames_seen > WARMUP) begin
        span = longint'(max_mot) - longint'(min_mot);
        if (span == 0) begin
          pct = 0;
        end else begin
          pct = ((longint'(motion_acc) - longint'(min_mot)) * 100) / span;
          if (pct > 32767)  pct = 32767;
          if (pct < -32768) pct = -32768;
        end
        res.area_valid = 1'b1;
        res.sum        = motion_acc[23:0];
        res.percent    = pct[15:0];
        res.triggered  = motion_acc > min_mot;
      end
      motion_acc = 0;
      if (frames_seen < 15) frames_seen++;
    end
  endtask

  // input acceptance and output check, sampled at the rising edge
  always @(posedge clk) begin : watch
    pixel_beat_t    seen;
    motion_result_t due;
    motion_result_t want;
    if (rst) begin
      in_beat = 1'b0;
    end else begin
      in_beat = s_tvalid && s_tready;
      if (in_beat) begin
        seen.pixel = s_tdata[7:0];
        seen.col   = s_tdata[15:8];
        seen.row   = s_tdata[23:16];
        seen.eof   = s_tlast;
        predict_motion(seen, due);
        motion_due_q.push_back(due);
      end
      if (m_tvalid && m_tready) begin
        if (motion_due_q.size() == 0) begin
          flag_error($sformatf("unexpected beat tdata=%h tuser=%b", m_tdata, m_tuser));
        end else begin
          want = motion_due_q.pop_front();
          if (m_tdata[7:0] !== want.diff)
            flag_error($sformatf("diff_value got %0d want %0d", m_tdata[7:0], want.diff));
          if (m_tuser !== want.area_valid)
            flag_error($sformatf("area_valid got %b want %b", m_tuser, want.area_valid));
          if (m_tdata[31:8] !== want.sum)
            flag_error($sformatf("motion_sum got %0d want %0d", m_tdata[31:8], want.sum));
          if (m_tdata[47:32] !== want.percent)
            flag_error($sformatf("motion_percent got %0d want %0d",
                                 $signed(m_tdata[47:32]), $signed(want.percent)));
          if (m_tdata[48] !== want.triggered)
            flag_error($sformatf("triggered got %b want %b", m_tdata[48], want.triggered));
        end
      end
    end
  end

  // pixel driver and output back-pressure, updated at the falling edge
  always @(negedge clk) begin : drive
    pixel_beat_t nxt;
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_beat) begin
      if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pixel_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {nxt.row, nxt.col, nxt.pixel};
        s_tlast  <= nxt.eof;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_AVG_FRAMES:  avg_sel  = 32'(val[2:0]);
      REG_AREA_LEFT:   left_col = 32'(val[7:0]);
      REG_AREA_TOP:    top_row  = int'($signed(val[8:0]));
      REG_AREA_WIDTH:  rect_w   = 32'(val[8:0]);
      REG_AREA_HEIGHT: rect_h   = 32'(val[8:0]);
      REG_MIN_MOTION:  min_mot  = 32'(val);
      REG_MAX_MOTION:  max_mot  = 32'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int unsigned avg, input int unsigned left, input int top,
                            input int unsigned w, input int unsigned h,
                            input int unsigned mn, input int unsigned mx);
    write_reg(REG_AVG_FRAMES, 24'(avg));
    write_reg(REG_AREA_LEFT, 24'(left));
    write_reg(REG_AREA_TOP, 24'(top & 'h1FF));
    write_reg(REG_AREA_WIDTH, 24'(w));
    write_reg(REG_AREA_HEIGHT, 24'(h));
    write_reg(REG_MIN_MOTION, 24'(mn));
    write_reg(REG_MAX_MOTION, 24'(mx));
  endtask

  task automatic push_px(input logic [7:0] pixel, input logic [7:0] col,
                         input logic [7:0] row, input logic eof);
    pixel_beat_t b;
    b.pixel = pixel;
    b.col   = col;
    b.row   = row;
    b.eof   = eof;
    pixel_q.push_back(b);
  endtask

  // everything sent and answered, then let the divider settle
  task automatic wait_idle();
    do @(posedge clk); while (pixel_q.size() != 0 || s_tvalid || motion_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one random setting followed by sweeps of a small pixel grid and stray pixels
  task automatic random_segment(input int items);
    logic [7:0]  gx;
    logic [7:0]  gy;
    logic [7:0]  v;
    logic [7:0]  bg [0:15];
    int          gw;
    int          gh;
    int          n;
    int          i;
    int          kind;
    int          cut;
    bit          jolt;
    int unsigned avg;
    int unsigned left;
    int          top;
    int unsigned w;
    int unsigned h;
    int unsigned mn;
    int unsigned mx;
    gx = 8'($urandom_range(0, 255));
    gy = 8'($urandom_range(0, 255));
    gw = $urandom_range(1, 4);
    gh = $urandom_range(1, 4);
    for (i = 0; i < 16; i++) bg[i] = 8'($urandom_range(0, 255));

    // rectangle: whole frame, around the grid, anywhere, or above the frame
    avg = $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0: begin
        left = 0; top = 0; w = 256; h = 256;
      end
      1: begin
        left = 32'(gx); top = int'(gy) - int'($urandom_range(0, 1));
        w = $urandom_range(0, gw + 1); h = $urandom_range(0, gh + 1);
      end
      2: begin
        left = $urandom_range(0, 255); top = int'($urandom_range(0, 511)) - 256;
        w = $urandom_range(0, 256); h = $urandom_range(0, 256);
      end
      default: begin
        left = 255; top = -256; w = 256; h = $urandom_range(0, 256);
      end
    endcase

    // thresholds: equal, ordered, reversed, full range, tiny span
    case ($urandom_range(0, 4))
      0: begin
        mn = $urandom_range(0, 3000); mx = mn;
      end
      1: begin
        mn = $urandom_range(0, 500); mx = mn + $urandom_range(1, 3000);
      end
      2: begin
        mx = $urandom_range(0, 2000); mn = mx + $urandom_range(1, 2000);
      end
      3: begin
        mn = $urandom_range(0, 16711680); mx = $urandom_range(0, 16711680);
      end
      default: begin
        mn = 0; mx = $urandom_range(1, 4);
      end
    endcase
    set_config(avg, left, top, w, h, mn, mx);

    n = 0;
    while (n < items) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        // stray pixel anywhere
        push_px(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        n++;
      end else begin
        // grid sweep; a few are cut short or lose their frame mark
        jolt = ($urandom_range(0, 3) == 0);
        cut  = (kind < 20) ? $urandom_range(1, gw * gh) : gw * gh;
        for (i = 0; i < cut; i++) begin
          v = jolt ? 8'($urandom) : bg[i] + 8'($urandom_range(0, 8)) - 8'd4;
          push_px(v, gx + 8'(i % gw), gy + 8'(i / gw), (i == cut - 1) && (kind != 15));
          n++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int seg;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_config(4, 0, 0, 256, 256, 0, 1000);
    // warm-up: one-pixel frames on one position, no report yet
    push_px(255, 0, 0, 1); push_px(0, 0, 0, 1);   push_px(255, 0, 0, 1);
    push_px(255, 0, 0, 1); push_px(0, 0, 0, 1);   push_px(128, 0, 0, 1);
    push_px(255, 0, 0, 1); push_px(17, 0, 0, 1);  push_px(0, 0, 0, 1);
    push_px(255, 0, 0, 1); push_px(64, 0, 0, 1);
    // first reported frame, corners of the coordinate range
    push_px(0, 0, 0, 0); push_px(255, 255, 255, 0);
    push_px(200, 0, 255, 0); push_px(1, 255, 0, 1);
    wait_idle();

    // equal bounds give zero percent
    set_config(2, 0, 0, 256, 256, 50, 50);
    push_px(90, 0, 0, 1);
    wait_idle();
    // max below min: negative divisor
    set_config(3, 0, 0, 256, 256, 16711680, 16711679);
    push_px(7, 0, 0, 1);
    wait_idle();
    // sum far under min saturates low
    set_config(0, 0, 0, 256, 256, 1000, 1001);
    push_px(3, 0, 0, 1);
    wait_idle();
    // rectangle in the far corner, starting one row above the frame
    set_config(1, 255, -1, 256, 256, 0, 10);
    push_px(40, 255, 254, 0); push_px(220, 255, 255, 0); push_px(99, 254, 0, 1);
    wait_idle();

    // random sweeps, rotating through the stall patterns
    for (seg = 0; seg < 16; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      random_segment(68);
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS frame_average_motion_detector");
    end else begin
      $display("FAIL frame_average_motion_detector");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("FAIL frame_average_motion_detector");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/fadet_pkg.sv
rtl/core/fadet_div.sv
rtl/core/frame_average_motion_detector.sv
sim/tb_frame_average_motion_detector.sv
